@@ rtl/hrl_pkg.sv @@
// shared types and constants for the hex record loader
`default_nettype none
package hrl_pkg;

    localparam int BUFFER_BYTES_DEF = 32;

    typedef enum logic [2:0] {
        KIND_DATA      = 3'd0,
        KIND_END       = 3'd1,
        KIND_BAD_DIGIT = 3'd2,
        KIND_BAD_COUNT = 3'd3,
        KIND_BAD_SUM   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        FLD_COUNT,
        FLD_ADDR,
        FLD_TYPE,
        FLD_DATA,
        FLD_CHECK
    } field_t;

    typedef struct packed {
        logic   start_rec;
        logic   take_digit;
        field_t fld;
        logic   emit_start;
        logic   emit_next;
        logic   load;
        kind_t  kind;
    } hrl_cmd_t;

    typedef struct packed {
        logic is_colon;
        logic hex_ok;
        logic nib_half;
        logic addr_second;
        logic count_too_big;
        logic count_zero;
        logic type_nonzero;
        logic data_last;
        logic sum_zero_next;
        logic emit_last;
        logic out_free;
    } hrl_status_t;

endpackage
`default_nettype wire

@@ rtl/hrl_if.sv @@
// stream interfaces for characters in and results out
`default_nettype none
interface hrl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

interface hrl_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] address;
    logic [7:0]  data_byte;
    logic [15:0] high_address;
    logic        last;

    modport source (output valid, output kind, output address, output data_byte,
                    output high_address, output last, input ready);
    modport sink (input valid, input kind, input address, input data_byte,
                  input high_address, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/hrl_datapath.sv @@
// record datapath: digit decode, fields, checksum, data buffer, output register
`default_nettype none
module hrl_datapath #(
    parameter int BUFFER_BYTES = hrl_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         char_code,
    input  wire hrl_pkg::hrl_cmd_t  cmd,
    output hrl_pkg::hrl_status_t    st,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic [2:0]              out_kind,
    output logic [15:0]             out_address,
    output logic [7:0]              out_data_byte,
    output logic [15:0]             out_high_address,
    output logic                    out_last
);
    import hrl_pkg::*;

    localparam int FI_W = $clog2(BUFFER_BYTES + 1);
    localparam int AW   = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam logic [7:0]  COLON     = 8'h3a;
    localparam logic [15:0] ADDR_ONES = 16'hffff;
    localparam logic [15:0] ADDR_ZERO = 16'h0000;

    logic            nib_half_reg;
    logic [3:0]      high_nibble_reg;
    logic [7:0]      byte_count_reg;
    logic [FI_W-1:0] field_index_reg;
    logic [15:0]     record_address_reg;
    logic            type_nonzero_reg;
    logic [7:0]      running_sum_reg;
    logic [15:0]     lowest_address_reg;
    logic [15:0]     highest_address_reg;
    logic [FI_W-1:0] emit_idx_reg;
    logic [7:0]      rd_data_reg;
    logic [7:0]      data_mem [BUFFER_BYTES];

    logic            out_valid_reg;
    logic [2:0]      out_kind_reg;
    logic [15:0]     out_address_reg;
    logic [7:0]      out_data_reg;
    logic [15:0]     out_high_reg;
    logic            out_last_reg;

    logic [3:0]      nib_val;
    logic            hex_ok;
    logic [7:0]      byte_val;
    logic [7:0]      sum_next;
    logic            byte_done;
    logic            wr_en;
    logic [15:0]     record_end;

    always_comb
    begin
        hex_ok  = 1'b1;
        nib_val = 4'd0;
        if (char_code inside {[8'h30:8'h39]})
        begin
            nib_val = 4'(char_code - 8'h30);
        end
        else if (char_code inside {[8'h41:8'h46]})
        begin
            nib_val = 4'(char_code - 8'h37);
        end
        else if (char_code inside {[8'h61:8'h66]})
        begin
            nib_val = 4'(char_code - 8'h57);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign byte_val   = {high_nibble_reg, nib_val};
    assign sum_next   = running_sum_reg + byte_val;
    assign byte_done  = cmd.take_digit && nib_half_reg;
    assign wr_en      = byte_done && (cmd.fld == FLD_DATA);
    assign record_end = record_address_reg + {8'd0, byte_count_reg};

    always_comb
    begin
        st.is_colon      = (char_code == COLON);
        st.hex_ok        = hex_ok;
        st.nib_half      = nib_half_reg;
        st.addr_second   = field_index_reg[0];
        st.count_too_big = (byte_count_reg > 8'(BUFFER_BYTES));
        st.count_zero    = (byte_count_reg == 8'd0);
        st.type_nonzero  = type_nonzero_reg;
        st.data_last     = ({1'b0, 8'(field_index_reg)} + 9'd1) >= {1'b0, byte_count_reg};
        st.sum_zero_next = (sum_next == 8'd0);
        st.emit_last     = (8'(emit_idx_reg) + 8'd1) == byte_count_reg;
        st.out_free      = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nib_half_reg        <= 1'b0;
            high_nibble_reg     <= 4'd0;
            byte_count_reg      <= 8'd0;
            field_index_reg     <= '0;
            record_address_reg  <= ADDR_ZERO;
            type_nonzero_reg    <= 1'b0;
            running_sum_reg     <= 8'd0;
            lowest_address_reg  <= ADDR_ONES;
            highest_address_reg <= ADDR_ZERO;
            emit_idx_reg        <= '0;
        end
        else
        begin
            if (cmd.start_rec)
            begin
                nib_half_reg    <= 1'b0;
                field_index_reg <= '0;
                running_sum_reg <= 8'd0;
            end
            else if (cmd.take_digit)
            begin
                if (!nib_half_reg)
                begin
                    high_nibble_reg <= nib_val;
                    nib_half_reg    <= 1'b1;
                end
                else
                begin
                    nib_half_reg    <= 1'b0;
                    running_sum_reg <= sum_next;
                    case (cmd.fld)
                        FLD_COUNT:
                        begin
                            byte_count_reg  <= byte_val;
                            field_index_reg <= '0;
                        end
                        FLD_ADDR:
                        begin
                            record_address_reg <= {record_address_reg[7:0], byte_val};
                            field_index_reg    <= field_index_reg[0] ? '0 : FI_W'(1);
                        end
                        FLD_TYPE:
                        begin
                            type_nonzero_reg <= (byte_val != 8'd0);
                            field_index_reg  <= '0;
                        end
                        FLD_DATA:
                        begin
                            field_index_reg <= field_index_reg + FI_W'(1);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            if (cmd.emit_start)
            begin
                emit_idx_reg <= '0;
                if (record_address_reg < lowest_address_reg)
                begin
                    lowest_address_reg <= record_address_reg;
                end
                if (record_end > highest_address_reg)
                begin
                    highest_address_reg <= record_end;
                end
            end
            else if (cmd.emit_next)
            begin
                emit_idx_reg <= emit_idx_reg + FI_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            data_mem[field_index_reg[AW-1:0]] <= byte_val;
        end
        rd_data_reg <= data_mem[emit_idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_kind_reg <= cmd.kind;
            case (cmd.kind)
                KIND_DATA:
                begin
                    out_address_reg <= record_address_reg + 16'(emit_idx_reg);
                    out_data_reg    <= rd_data_reg;
                    out_high_reg    <= ADDR_ZERO;
                    out_last_reg    <= st.emit_last;
                end
                KIND_END:
                begin
                    out_address_reg <= lowest_address_reg;
                    out_data_reg    <= 8'd0;
                    out_high_reg    <= highest_address_reg;
                    out_last_reg    <= 1'b1;
                end
                default:
                begin
                    out_address_reg <= ADDR_ZERO;
                    out_data_reg    <= 8'd0;
                    out_high_reg    <= ADDR_ZERO;
                    out_last_reg    <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_kind         = out_kind_reg;
    assign out_address      = out_address_reg;
    assign out_data_byte    = out_data_reg;
    assign out_high_address = out_high_reg;
    assign out_last         = out_last_reg;

endmodule
`default_nettype wire

@@ rtl/hrl_controller.sv @@
// record parsing and result sequencing state machine
`default_nettype none
module hrl_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire hrl_pkg::hrl_status_t st,
    output hrl_pkg::hrl_cmd_t         cmd
);
    import hrl_pkg::*;

    typedef enum logic [3:0] {
        S_HUNT,
        S_COUNT,
        S_ADDR,
        S_TYPE,
        S_DATA,
        S_CHECK,
        S_READ,
        S_SHOW,
        S_HALT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_fire;

    always_comb
    begin
        case (state_reg)
            S_READ, S_SHOW: in_ready = 1'b0;
            default:        in_ready = st.out_free;
        endcase
    end

    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.fld        = FLD_COUNT;
        cmd.kind       = KIND_DATA;
        case (state_reg)
            S_HUNT:
            begin
                if (in_fire && st.is_colon)
                begin
                    cmd.start_rec = 1'b1;
                    state_next    = S_COUNT;
                end
            end
            S_COUNT, S_ADDR, S_TYPE, S_DATA, S_CHECK:
            begin
                case (state_reg)
                    S_COUNT: cmd.fld = FLD_COUNT;
                    S_ADDR:  cmd.fld = FLD_ADDR;
                    S_TYPE:  cmd.fld = FLD_TYPE;
                    S_DATA:  cmd.fld = FLD_DATA;
                    default: cmd.fld = FLD_CHECK;
                endcase
                if (in_fire)
                begin
                    if (!st.hex_ok)
                    begin
                        cmd.load   = 1'b1;
                        cmd.kind   = KIND_BAD_DIGIT;
                        state_next = S_HALT;
                    end
                    else
                    begin
                        cmd.take_digit = 1'b1;
                        if (st.nib_half)
                        begin
                            case (state_reg)
                                S_COUNT: state_next = S_ADDR;
                                S_ADDR:
                                begin
                                    if (st.addr_second)
                                    begin
                                        state_next = S_TYPE;
                                    end
                                end
                                S_TYPE:
                                begin
                                    if (st.count_too_big)
                                    begin
                                        cmd.load   = 1'b1;
                                        cmd.kind   = KIND_BAD_COUNT;
                                        state_next = S_HALT;
                                    end
                                    else
                                    begin
                                        state_next = st.count_zero ? S_CHECK : S_DATA;
                                    end
                                end
                                S_DATA:
                                begin
                                    if (st.data_last)
                                    begin
                                        state_next = S_CHECK;
                                    end
                                end
                                default:
                                begin
                                    if (!st.sum_zero_next)
                                    begin
                                        cmd.load   = 1'b1;
                                        cmd.kind   = KIND_BAD_SUM;
                                        state_next = S_HALT;
                                    end
                                    else if (st.type_nonzero || st.count_zero)
                                    begin
                                        cmd.load   = 1'b1;
                                        cmd.kind   = KIND_END;
                                        state_next = S_HALT;
                                    end
                                    else
                                    begin
                                        cmd.emit_start = 1'b1;
                                        state_next     = S_READ;
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
            S_READ:
            begin
                state_next = S_SHOW;
            end
            S_SHOW:
            begin
                if (st.out_free)
                begin
                    cmd.load = 1'b1;
                    cmd.kind = KIND_DATA;
                    if (st.emit_last)
                    begin
                        state_next = S_HUNT;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_HALT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/hex_record_loader_core.sv @@
// top level of the hex record loader
// Parses hex records one character per transaction: text outside a record is
// skipped until ':', then count, address, type, data and checksum are read as
// hex pairs. While a record is being read the block takes one character every
// cycle, as long as the result register is free. After a good data record it
// accepts no character while it replays the buffered bytes: each byte passes
// through the buffer memory read register, then the result register, and the
// replay waits whenever the result side stalls. An end record or any error
// gives one result and halts the block until reset; characters are then still
// taken and dropped.
`default_nettype none
module hex_record_loader_core #(
    parameter int BUFFER_BYTES = hrl_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hrl_char_if.sink   text,
    hrl_result_if.source result
);
    import hrl_pkg::*;

    hrl_cmd_t    cmd;
    hrl_status_t st;

    hrl_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text.valid),
        .in_ready (text.ready),
        .st       (st),
        .cmd      (cmd)
    );

    hrl_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .char_code        (text.char_code),
        .cmd              (cmd),
        .st               (st),
        .out_ready        (result.ready),
        .out_valid        (result.valid),
        .out_kind         (result.kind),
        .out_address      (result.address),
        .out_data_byte    (result.data_byte),
        .out_high_address (result.high_address),
        .out_last         (result.last)
    );

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// testbench for hex_record_loader_core: record streams against a cycle-free parser model
`timescale 1ns / 1ps
module tb_top;
    import hrl_pkg::*;

    localparam int BUFFER_BYTES = BUFFER_BYTES_DEF;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 100;

    localparam logic [7:0] CHAR_COLON   = 8'h3a;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    typedef enum logic [2:0] {
        P_HUNT,
        P_COUNT,
        P_ADDR,
        P_TYPE,
        P_DATA,
        P_CHECK
    } parse_phase_t;

    typedef enum int {
        TERM_EOF_RECORD,
        TERM_EMPTY_DATA,
        TERM_TYPED_DATA,
        TERM_BAD_DIGIT,
        TERM_BAD_COUNT,
        TERM_BAD_SUM
    } termination_t;

    typedef struct {
        kind_t       kind;
        logic [15:0] address;
        logic [7:0]  data_byte;
        logic [15:0] high_address;
        logic        last;
    } load_result_t;

    logic clk;
    logic rst_n;

    hrl_char_if   text_if ();
    hrl_result_if result_if ();

    hex_record_loader_core #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_if),
        .result(result_if)
    );

    load_result_t expected_results[$];
    logic [7:0]   payload_bytes[$];
    int           error_count;
    bit           gaps_on;
    int           hold_request;
    int           hold_left;

    // parser model state
    parse_phase_t p_phase;
    logic         p_half;
    logic [3:0]   p_high_nib;
    logic [7:0]   p_count;
    int           p_index;
    logic [15:0]  p_rec_addr;
    logic         p_type_nz;
    logic [7:0]   p_sum;
    logic [7:0]   p_buffer[BUFFER_BYTES];
    logic [15:0]  p_lowest;
    logic [15:0]  p_highest;
    logic         p_halted;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        error_count++;
    endtask

    function automatic int hex_digit_value(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_ZERO + 8'd9)
            return int'(c - CHAR_ZERO);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_A + 8'd5)
            return int'(c - CHAR_UPPER_A) + 10;
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_A + 8'd5)
            return int'(c - CHAR_LOWER_A) + 10;
        return -1;
    endfunction

    function automatic void push_result(input kind_t k, input logic [15:0] a,
                                        input logic [7:0] d, input logic [15:0] h,
                                        input logic l);
        load_result_t r;
        r.kind = k;
        r.address = a;
        r.data_byte = d;
        r.high_address = h;
        r.last = l;
        expected_results.push_back(r);
    endfunction

    function automatic void halt_load(input kind_t k);
        p_halted = 1'b1;
        push_result(k, 16'h0000, 8'h00, 16'h0000, 1'b1);
    endfunction

    function automatic void reset_parser();
        p_phase = P_HUNT;
        p_half = 1'b0;
        p_high_nib = 4'h0;
        p_count = 8'h00;
        p_index = 0;
        p_rec_addr = 16'h0000;
        p_type_nz = 1'b0;
        p_sum = 8'h00;
        p_lowest = 16'hffff;
        p_highest = 16'h0000;
        p_halted = 1'b0;
    endfunction

    // advance the parser by one accepted character and queue what it emits
    function automatic void parse_char(input logic [7:0] c);
        int v;
        int n;
        logic [7:0] b;
        logic [15:0] end_addr;
        if (p_halted)
            return;
        if (p_phase == P_HUNT)
        begin
            if (c == CHAR_COLON)
            begin
                p_phase = P_COUNT;
                p_half = 1'b0;
                p_index = 0;
                p_sum = 8'h00;
            end
            return;
        end
        v = hex_digit_value(c);
        if (v < 0)
        begin
            halt_load(KIND_BAD_DIGIT);
            return;
        end
        if (!p_half)
        begin
            p_high_nib = v[3:0];
            p_half = 1'b1;
            return;
        end
        p_half = 1'b0;
        b = {p_high_nib, v[3:0]};
        p_sum = p_sum + b;
        case (p_phase)
            P_COUNT:
            begin
                p_count = b;
                p_phase = P_ADDR;
                p_index = 0;
            end
            P_ADDR:
            begin
                p_rec_addr = {p_rec_addr[7:0], b};
                if (p_index == 0)
                    p_index = 1;
                else
                begin
                    p_index = 0;
                    p_phase = P_TYPE;
                end
            end
            P_TYPE:
            begin
                p_type_nz = (b != 8'h00);
                if (int'(p_count) > BUFFER_BYTES)
                begin
                    halt_load(KIND_BAD_COUNT);
                    return;
                end
                p_index = 0;
                p_phase = (p_count == 8'h00) ? P_CHECK : P_DATA;
            end
            P_DATA:
            begin
                if (p_index < BUFFER_BYTES)
                    p_buffer[p_index] = b;
                p_index++;
                if (p_index >= int'(p_count))
                    p_phase = P_CHECK;
            end
            default:
            begin
                if (p_sum != 8'h00)
                begin
                    halt_load(KIND_BAD_SUM);
                    return;
                end
                if (p_type_nz || p_count == 8'h00)
                begin
                    p_halted = 1'b1;
                    push_result(KIND_END, p_lowest, 8'h00, p_highest, 1'b1);
                    return;
                end
                if (p_rec_addr < p_lowest)
                    p_lowest = p_rec_addr;
                n = int'(p_count);
                for (int i = 0; i < n; i++)
                    push_result(KIND_DATA, p_rec_addr + 16'(i), p_buffer[i], 16'h0000,
                                i == n - 1);
                end_addr = p_rec_addr + 16'(n);
                if (end_addr > p_highest)
                    p_highest = end_addr;
                p_phase = P_HUNT;
                p_index = 0;
            end
        endcase
    endfunction

    // result receiver with random stalls and a counted hold-off
    initial
    begin
        result_if.ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= !(gaps_on && $urandom_range(0, 99) < 6);
        end
    end

    always @(posedge clk)
    begin
        load_result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing pending, kind", result_if.kind, 0);
            else
            begin
                want = expected_results.pop_front();
                if (result_if.kind !== want.kind)
                    report_mismatch("kind", result_if.kind, want.kind);
                if (result_if.address !== want.address)
                    report_mismatch("address", result_if.address, want.address);
                if (result_if.data_byte !== want.data_byte)
                    report_mismatch("data_byte", result_if.data_byte, want.data_byte);
                if (result_if.high_address !== want.high_address)
                    report_mismatch("high_address", result_if.high_address,
                                    want.high_address);
                if (result_if.last !== want.last)
                    report_mismatch("last", result_if.last, want.last);
            end
        end
    end

    // one character transaction, entered and left at a falling edge
    task send_char(input logic [7:0] c);
        while (gaps_on && $urandom_range(0, 99) < 6)
        begin
            text_if.valid <= 1'b0;
            @(negedge clk);
        end
        text_if.valid <= 1'b1;
        text_if.char_code <= c;
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
        parse_char(c);
        @(negedge clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return CHAR_ZERO + 8'(nib);
        if ($urandom_range(0, 1) == 0)
            return CHAR_UPPER_A + 8'(nib) - 8'd10;
        return CHAR_LOWER_A + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0)
            return CHAR_COLON;
        c = 8'($urandom_range(0, 255));
        while (hex_digit_value(c) >= 0)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CHAR_COLON)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task fill_payload(input int n);
        payload_bytes.delete();
        repeat (n)
            payload_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // sends ':' and the record as hex pairs; bad_pos replaces one digit
    task automatic send_record(input logic [7:0] count, input logic [15:0] addr,
                               input logic [7:0] rtype, input logic [7:0] sum_skew,
                               input int bad_pos);
        logic [7:0] rec_bytes[$];
        logic [7:0] sum;
        int k;
        rec_bytes.push_back(count);
        rec_bytes.push_back(addr[15:8]);
        rec_bytes.push_back(addr[7:0]);
        rec_bytes.push_back(rtype);
        foreach (payload_bytes[i])
            rec_bytes.push_back(payload_bytes[i]);
        sum = 8'h00;
        foreach (rec_bytes[i])
            sum = sum + rec_bytes[i];
        sum = 8'h00 - sum + sum_skew;
        rec_bytes.push_back(sum);
        send_char(CHAR_COLON);
        k = 0;
        foreach (rec_bytes[i])
        begin
            send_char(k == bad_pos ? non_hex_char() : hex_char(rec_bytes[i][7:4]));
            k++;
            send_char(k == bad_pos ? non_hex_char() : hex_char(rec_bytes[i][3:0]));
            k++;
        end
    endtask

    task wait_results_drained(input int max_cycles);
        int waited;
        waited = 0;
        while (expected_results.size() != 0 && waited < max_cycles)
        begin
            @(negedge clk);
            waited++;
        end
    endtask

    task pause_until_drained();
        text_if.valid <= 1'b0;
        wait_results_drained(DRAIN_LIMIT);
        @(negedge clk);
    endtask

    task test_ignored_text();
        send_char(8'h00);
        send_char(8'hff);
        send_char(8'h80);
        send_char(8'h7f);
    endtask

    // wrap from 0xffff to 0x0000 with extreme data values
    task test_directed_records();
        payload_bytes.delete();
        payload_bytes.push_back(8'h00);
        payload_bytes.push_back(8'hff);
        send_record(8'd2, 16'hffff, 8'h00, 8'h00, -1);
    endtask

    // full buffer while the receiver holds off, then a drain with the sender idle
    task test_output_backpressure();
        hold_request = HOLD_CYCLES;
        fill_payload(BUFFER_BYTES);
        send_record(8'(BUFFER_BYTES), 16'hfff0, 8'h00, 8'h00, -1);
        fill_payload(3);
        send_record(8'd3, 16'h0000, 8'h00, 8'h00, -1);
        pause_until_drained();
    endtask

    task test_random_records();
        int sent;
        int n;
        int r;
        logic [15:0] a;
        sent = 0;
        while (sent < 100)
        begin
            gaps_on = !(sent >= 20 && sent < 80);
            repeat ($urandom_range(0, 3))
                send_char(noise_char());
            r = $urandom_range(0, 9);
            if (r < 7)
                n = $urandom_range(1, 6);
            else if (r < 9)
                n = $urandom_range(7, 16);
            else
                n = $urandom_range(17, BUFFER_BYTES);
            r = $urandom_range(0, 9);
            if (r == 0)
                a = 16'($urandom_range(16'hffe0, 16'hffff));
            else if (r == 1)
                a = 16'($urandom_range(0, 16'h0040));
            else
                a = 16'($urandom_range(0, 16'hffff));
            fill_payload(n);
            send_record(8'(n), a, 8'h00, 8'h00, -1);
            sent += 11 + 2 * n;
        end
        gaps_on = 1'b1;
    endtask

    task test_load_termination();
        termination_t term;
        int n;
        term = termination_t'($urandom_range(int'(TERM_EOF_RECORD), int'(TERM_BAD_SUM)));
        n = $urandom_range(1, 4);
        fill_payload(n);
        case (term)
            TERM_EOF_RECORD:
            begin
                payload_bytes.delete();
                send_record(8'd0, 16'($urandom_range(0, 16'hffff)), 8'h01, 8'h00, -1);
            end
            TERM_EMPTY_DATA:
            begin
                payload_bytes.delete();
                send_record(8'd0, 16'($urandom_range(0, 16'hffff)), 8'h00, 8'h00, -1);
            end
            TERM_TYPED_DATA:
                send_record(8'(n), 16'($urandom_range(0, 16'hffff)),
                            8'($urandom_range(1, 255)), 8'h00, -1);
            TERM_BAD_DIGIT:
                send_record(8'(n), 16'($urandom_range(0, 16'hffff)), 8'h00, 8'h00,
                            $urandom_range(0, 2 * (5 + n) - 1));
            TERM_BAD_COUNT:
            begin
                payload_bytes.delete();
                send_record(8'($urandom_range(BUFFER_BYTES + 1, 255)),
                            16'($urandom_range(0, 16'hffff)),
                            8'($urandom_range(0, 255)), 8'h00, -1);
            end
            default:
                send_record(8'(n), 16'($urandom_range(0, 16'hffff)), 8'h00,
                            8'($urandom_range(1, 255)), -1);
        endcase
    endtask

    // everything after the halt is taken and dropped
    task test_halted_input();
        send_char(CHAR_COLON);
        repeat (20)
            send_char(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        error_count = 0;
        gaps_on = 1'b1;
        hold_request = 0;
        reset_parser();
        text_if.valid = 1'b0;
        text_if.char_code = 8'h00;
        rst_n = 1'b0;
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_ignored_text();
        test_directed_records();
        test_output_backpressure();
        test_random_records();
        test_load_termination();
        test_halted_input();
        text_if.valid <= 1'b0;
        wait_results_drained(DRAIN_LIMIT);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never delivered, count", expected_results.size(), 0);
        if (error_count == 0)
            $display("** hex_record_loader_core: PASSED **");
        else
            $display("** hex_record_loader_core: FAILED **");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("** hex_record_loader_core: FAILED **");
        $finish;
    end

endmodule
